/* hdl/tbdd_pkg.sv */
// ---------------------------------------------------------------------------
// tbdd_pkg
// Shared types, register indexes and reset values of the touch pad
// baseline / debounce detector.
// ---------------------------------------------------------------------------
package tbdd_pkg;

  // default level format: integer and fraction bits
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 8;

  // gain format: Q0.16 with one extra bit so that 65536 means one
  localparam int ALPHA_W = 17;

  // configuration port
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE_ALPHA  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THRESH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_RISING    = 3'd6;

  // register reset values
  localparam logic [15:0]        RST_SAMPLE_INTERVAL = 16'd20;
  localparam logic [ALPHA_W-1:0] RST_FILTER_ALPHA    = 17'd16384;
  localparam logic [ALPHA_W-1:0] RST_BASELINE_ALPHA  = 17'd66;
  localparam logic [15:0]        RST_PRESS_THRESHOLD = 16'd200;
  localparam logic [16:0]        RST_RELEASE_THRESH  = 17'd100;
  localparam logic [7:0]         RST_DEBOUNCE        = 8'd3;
  localparam logic               RST_PRESS_RISING    = 1'b0;

  // debounce counter saturation
  localparam logic [7:0] CNT_MAX = 8'hFF;

  // input request
  typedef struct packed {
    logic [31:0] time_ms;
    logic [15:0] raw_sample;
  } in_t;

  // result request
  typedef struct packed {
    logic press_event;
    logic held;
    logic sample_taken;
  } out_t;

endpackage

/* hdl/tbdd_track.sv */
// ---------------------------------------------------------------------------
// tbdd_track
// Bit-serial level tracker: level + floor(alpha * (target - level) / 65536),
// clamped to the level range. One gain bit per cycle, 17 steps per update.
// ---------------------------------------------------------------------------
module tbdd_track #(
  parameter int LEVEL_W = tbdd_pkg::SAMPLE_BITS_DEF + tbdd_pkg::FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [LEVEL_W-1:0]         level,
  input  logic [LEVEL_W-1:0]         target,
  input  logic [tbdd_pkg::ALPHA_W-1:0] alpha,
  output logic                       done,
  output logic [LEVEL_W-1:0]         result
);

  localparam int DIFF_W    = LEVEL_W + 1;
  localparam int ACC_W     = LEVEL_W + 2;
  localparam int SUM_W     = LEVEL_W + 3;
  localparam int SUMV_W    = LEVEL_W + 4;
  localparam int STEP_W    = $clog2(tbdd_pkg::ALPHA_W);
  localparam int LAST_STEP = tbdd_pkg::ALPHA_W - 1;

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [STEP_W-1:0]              step_r, step_nxt;
  logic [tbdd_pkg::ALPHA_W-1:0]   alpha_sr_r, alpha_sr_nxt;
  logic signed [DIFF_W-1:0]       diff_r, diff_nxt;
  logic signed [ACC_W-1:0]        acc_r, acc_nxt;
  logic [LEVEL_W-1:0]             level_r, level_nxt;
  logic [LEVEL_W-1:0]             result_r, result_nxt;

  logic signed [SUM_W-1:0]        addend;
  logic signed [SUM_W-1:0]        sum;
  logic signed [SUMV_W-1:0]       total;
  logic [LEVEL_W-1:0]             clamped;

  // one partial product per cycle, shifted right so the adder stays narrow
  always_comb begin
    addend  = alpha_sr_r[0] ? $signed({{2{diff_r[DIFF_W-1]}}, diff_r})
                            : '0;
    sum     = $signed({acc_r[ACC_W-1], acc_r}) + addend;
    total   = $signed({4'b0000, level_r}) + $signed({sum[SUM_W-1], sum});
    if (total[SUMV_W-1]) begin
      clamped = '0;
    end else if (total[SUMV_W-2:LEVEL_W] != '0) begin
      clamped = '1;
    end else begin
      clamped = total[LEVEL_W-1:0];
    end
  end

  // step sequencing
  always_comb begin
    busy_nxt     = busy_r;
    done_nxt     = 1'b0;
    step_nxt     = step_r;
    alpha_sr_nxt = alpha_sr_r;
    diff_nxt     = diff_r;
    acc_nxt      = acc_r;
    level_nxt    = level_r;
    result_nxt   = result_r;
    if (start) begin
      busy_nxt     = 1'b1;
      step_nxt     = '0;
      alpha_sr_nxt = alpha;
      diff_nxt     = $signed({1'b0, target}) - $signed({1'b0, level});
      acc_nxt      = '0;
      level_nxt    = level;
    end else if (busy_r) begin
      if (step_r == STEP_W'(LAST_STEP)) begin
        // top gain bit weighs 65536: added without a shift
        busy_nxt   = 1'b0;
        done_nxt   = 1'b1;
        result_nxt = clamped;
      end else begin
        acc_nxt      = sum[SUM_W-1:1];
        alpha_sr_nxt = alpha_sr_r >> 1;
        step_nxt     = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    alpha_sr_r <= alpha_sr_nxt;
    diff_r     <= diff_nxt;
    acc_r      <= acc_nxt;
    level_r    <= level_nxt;
    result_r   <= result_nxt;
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

/* hdl/touch_baseline_debounce_detect.sv */
// ---------------------------------------------------------------------------
// touch_baseline_debounce_detect
// Capacitive pad detector: interval gate, low-pass filter, baseline
// tracking, hysteresis thresholds and debounced press / release.
//
// Usage: an input request (time_ms, raw_sample) is taken when in_valid is
// high and in_stall low; every request yields exactly one result request
// (press_event, held, sample_taken) on the out_ channel. Registers are
// written through cfg_we / cfg_index / cfg_data while the block is idle.
// Flow: a gated or seeding request goes from idle straight to the done
// state. A tracked sample runs the bit-serial tracker (17 steps) for the
// filter, loads its result and takes the press / release decision; when
// the baseline also follows, a second tracker update and load come next.
// One request is in work at a time: the next is taken only once the
// block is back in idle. If the receiver stalls, a finished result
// waits in the output register while the next request is worked on; the
// result after it, and in_stall, stay held until that register is freed.
// Reset (rst_n low, synchronous) restores register defaults, clears the
// seeded, held and debounce state and empties the output register.
// ---------------------------------------------------------------------------
module touch_baseline_debounce_detect #(
  parameter int SAMPLE_BITS   = tbdd_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = tbdd_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tbdd_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tbdd_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [tbdd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbdd_pkg::CFG_W-1:0]      cfg_data
);

  localparam int LEVEL_W = SAMPLE_BITS + FRACTION_BITS;
  localparam int CMP_A   = LEVEL_W + 1;
  localparam int CMP_B   = FRACTION_BITS + 17;
  localparam int CMP_W   = ((CMP_A > CMP_B) ? CMP_A : CMP_B) + 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_FILT   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_BASE   = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  // configuration registers
  logic [15:0]                    intv_r;
  logic [tbdd_pkg::ALPHA_W-1:0]   falpha_r;
  logic [tbdd_pkg::ALPHA_W-1:0]   balpha_r;
  logic [15:0]                    pthr_r;
  logic [16:0]                    rthr_r;
  logic [7:0]                     deb_r;
  logic                           rising_r;

  // detector state
  state_t                         state_r, state_nxt;
  logic                           seeded_r, seeded_nxt;
  logic [31:0]                    last_r, last_nxt;
  logic [LEVEL_W-1:0]             filt_r, filt_nxt;
  logic [LEVEL_W-1:0]             base_r, base_nxt;
  logic                           held_r, held_nxt;
  logic [7:0]                     cnt_r, cnt_nxt;
  tbdd_pkg::out_t                 res_r, res_nxt;
  logic                           out_valid_r, out_valid_nxt;
  tbdd_pkg::out_t                 out_data_r, out_data_nxt;

  // tracker hookup
  logic                           trk_start;
  logic [LEVEL_W-1:0]             trk_level;
  logic [LEVEL_W-1:0]             trk_target;
  logic [tbdd_pkg::ALPHA_W-1:0]   trk_alpha;
  logic                           trk_done;
  logic [LEVEL_W-1:0]             trk_result;

  // datapath helpers
  logic                           accept;
  logic [SAMPLE_BITS-1:0]         raw_bits;
  logic [LEVEL_W-1:0]             raw_lvl;
  logic [31:0]                    elapsed;
  logic                           gated;
  logic signed [CMP_W-1:0]        filt_ext, base_ext, amount;
  logic signed [CMP_W-1:0]        pthr_ext, rthr_ext;
  logic                           press_hit, release_hit;
  logic [7:0]                     cnt_inc;
  logic                           cnt_reached;
  logic                           out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // reading in level format and interval gate
  assign raw_bits = SAMPLE_BITS'(in_data.raw_sample);
  assign raw_lvl  = {raw_bits, {FRACTION_BITS{1'b0}}};
  assign elapsed  = in_data.time_ms - last_r;
  assign gated    = seeded_r && (elapsed < 32'(intv_r));

  // touch amount and threshold tests
  always_comb begin
    filt_ext    = $signed(CMP_W'(filt_r));
    base_ext    = $signed(CMP_W'(base_r));
    amount      = rising_r ? (filt_ext - base_ext) : (base_ext - filt_ext);
    pthr_ext    = $signed(CMP_W'({pthr_r, {FRACTION_BITS{1'b0}}}));
    rthr_ext    = $signed({{(CMP_W - CMP_B){rthr_r[16]}}, rthr_r,
                           {FRACTION_BITS{1'b0}}});
    press_hit   = (amount >= pthr_ext);
    release_hit = (amount <= rthr_ext);
    cnt_inc     = (cnt_r == tbdd_pkg::CNT_MAX) ? cnt_r : cnt_r + 8'd1;
    cnt_reached = (cnt_inc >= deb_r);
  end

  // tracker operand select: filter from idle, baseline from the decision
  always_comb begin
    trk_start  = 1'b0;
    trk_level  = filt_r;
    trk_target = raw_lvl;
    trk_alpha  = falpha_r;
    if (state_r == ST_DECIDE) begin
      trk_level  = base_r;
      trk_target = filt_r;
      trk_alpha  = balpha_r;
      trk_start  = !held_r && !press_hit;
    end else if (accept) begin
      trk_start  = !gated && seeded_r;
    end
  end

  tbdd_track #(
    .LEVEL_W (LEVEL_W)
  ) u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (trk_start),
    .level  (trk_level),
    .target (trk_target),
    .alpha  (trk_alpha),
    .done   (trk_done),
    .result (trk_result)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    seeded_nxt    = seeded_r;
    last_nxt      = last_r;
    filt_nxt      = filt_r;
    base_nxt      = base_r;
    held_nxt      = held_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt.press_event  = 1'b0;
          res_nxt.held         = held_r;
          res_nxt.sample_taken = !gated;
          if (gated) begin
            state_nxt = ST_DONE;
          end else begin
            last_nxt = in_data.time_ms;
            if (!seeded_r) begin
              filt_nxt   = raw_lvl;
              base_nxt   = raw_lvl;
              seeded_nxt = 1'b1;
              state_nxt  = ST_DONE;
            end else begin
              state_nxt = ST_FILT;
            end
          end
        end
      end
      ST_FILT: begin
        if (trk_done) begin
          filt_nxt  = trk_result;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_nxt = ST_DONE;
        if (!held_r) begin
          if (press_hit) begin
            if (cnt_reached) begin
              held_nxt            = 1'b1;
              cnt_nxt             = '0;
              res_nxt.press_event = 1'b1;
              res_nxt.held        = 1'b1;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end else begin
            // not pressed: baseline follows the filtered level
            cnt_nxt   = '0;
            state_nxt = ST_BASE;
          end
        end else if (release_hit) begin
          if (cnt_reached) begin
            held_nxt     = 1'b0;
            cnt_nxt      = '0;
            res_nxt.held = 1'b0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end else begin
          cnt_nxt = '0;
        end
      end
      ST_BASE: begin
        if (trk_done) begin
          base_nxt  = trk_result;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hand the result over once the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seeded_r    <= 1'b0;
      held_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seeded_r    <= seeded_nxt;
      held_r      <= held_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_r     <= last_nxt;
    filt_r     <= filt_nxt;
    base_r     <= base_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intv_r   <= tbdd_pkg::RST_SAMPLE_INTERVAL;
      falpha_r <= tbdd_pkg::RST_FILTER_ALPHA;
      balpha_r <= tbdd_pkg::RST_BASELINE_ALPHA;
      pthr_r   <= tbdd_pkg::RST_PRESS_THRESHOLD;
      rthr_r   <= tbdd_pkg::RST_RELEASE_THRESH;
      deb_r    <= tbdd_pkg::RST_DEBOUNCE;
      rising_r <= tbdd_pkg::RST_PRESS_RISING;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tbdd_pkg::REG_SAMPLE_INTERVAL: intv_r   <= cfg_data[15:0];
        tbdd_pkg::REG_FILTER_ALPHA:    falpha_r <= cfg_data[16:0];
        tbdd_pkg::REG_BASELINE_ALPHA:  balpha_r <= cfg_data[16:0];
        tbdd_pkg::REG_PRESS_THRESHOLD: pthr_r   <= cfg_data[15:0];
        tbdd_pkg::REG_RELEASE_THRESH:  rthr_r   <= cfg_data[16:0];
        tbdd_pkg::REG_DEBOUNCE:        deb_r    <= cfg_data[7:0];
        tbdd_pkg::REG_PRESS_RISING:    rising_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* tb/sv/tbdd_monitor.sv */
// ---------------------------------------------------------------------------
// tbdd_monitor
// Watches the request, result and register ports of the touch pad detector.
// It keeps its own copy of the registers and of the detector state. For
// every accepted input request it works out the result request, and it
// compares each accepted result request with the oldest one outstanding.
// ---------------------------------------------------------------------------
module tbdd_monitor
  import tbdd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending
);

  localparam int     FRAC      = FRACTION_BITS_DEF;
  localparam int     LEVEL_W   = SAMPLE_BITS_DEF + FRACTION_BITS_DEF;
  localparam int     GAIN_FRAC = 16;
  localparam longint LEVEL_TOP = (longint'(1) <<< LEVEL_W) - 1;

  // register copies
  logic [15:0]        interval_ms;
  logic [ALPHA_W-1:0] filt_gain;
  logic [ALPHA_W-1:0] base_gain;
  logic [15:0]        press_thr;
  logic signed [16:0] release_thr;
  logic [7:0]         debounce_len;
  logic               rising;

  // detector state
  logic        seeded;
  logic [31:0] last_time;
  longint      filt_level;
  longint      base_level;
  logic        held_q;
  logic [7:0]  bounce_cnt;

  out_t touch_results_q[$];
  int   errors = 0;

  // level += floor(gain * (target - level) / 2^16), clamped to the level range
  function automatic longint follow(input longint level, input longint target,
                                    input logic [ALPHA_W-1:0] gain);
    longint nxt;
    nxt = level + ((longint'(gain) * (target - level)) >>> GAIN_FRAC);
    if (nxt < 0) nxt = 0;
    if (nxt > LEVEL_TOP) nxt = LEVEL_TOP;
    return nxt;
  endfunction

  // one more qualifying sample; saturates at the counter maximum
  function automatic logic count_hit();
    if (bounce_cnt != CNT_MAX) bounce_cnt = bounce_cnt + 8'd1;
    return bounce_cnt >= debounce_len;
  endfunction

  function automatic out_t predict_touch(input in_t req);
    out_t        res;
    logic [31:0] elapsed;
    longint      raw;
    longint      amount;
    res = '0;
    elapsed = req.time_ms - last_time;
    // too soon after the last accepted reading: state untouched
    if (seeded && elapsed < 32'(interval_ms)) begin
      res.held = held_q;
      return res;
    end
    last_time = req.time_ms;
    raw = longint'(req.raw_sample) <<< FRAC;
    if (!seeded) begin
      filt_level = raw;
      base_level = raw;
      seeded     = 1'b1;
    end else begin
      filt_level = follow(filt_level, raw, filt_gain);
      amount = rising ? filt_level - base_level : base_level - filt_level;
      if (!held_q) begin
        if (amount >= (longint'(press_thr) <<< FRAC)) begin
          if (count_hit()) begin
            held_q          = 1'b1;
            bounce_cnt      = '0;
            res.press_event = 1'b1;
          end
        end else begin
          // baseline only follows while the pad is quiet
          bounce_cnt = '0;
          base_level = follow(base_level, filt_level, base_gain);
        end
      end else if (amount <= longint'(release_thr) * (longint'(1) <<< FRAC)) begin
        if (count_hit()) begin
          held_q     = 1'b0;
          bounce_cnt = '0;
        end
      end else begin
        bounce_cnt = '0;
      end
    end
    res.held         = held_q;
    res.sample_taken = 1'b1;
    return res;
  endfunction

  function automatic void check_bit(input string field, input logic exp_b, input logic act_b);
    if (act_b !== exp_b) begin
      $display("%0t: %s mismatch: expected %b, actual %b", $time, field, exp_b, act_b);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_t exp_res;
    if (!rst_n) begin
      interval_ms  = RST_SAMPLE_INTERVAL;
      filt_gain    = RST_FILTER_ALPHA;
      base_gain    = RST_BASELINE_ALPHA;
      press_thr    = RST_PRESS_THRESHOLD;
      release_thr  = RST_RELEASE_THRESH;
      debounce_len = RST_DEBOUNCE;
      rising       = RST_PRESS_RISING;
      seeded       = 1'b0;
      last_time    = '0;
      filt_level   = 0;
      base_level   = 0;
      held_q       = 1'b0;
      bounce_cnt   = '0;
      touch_results_q.delete();
    end else begin
      // register writes; unknown indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          REG_SAMPLE_INTERVAL: interval_ms  = cfg_data[15:0];
          REG_FILTER_ALPHA:    filt_gain    = cfg_data[ALPHA_W-1:0];
          REG_BASELINE_ALPHA:  base_gain    = cfg_data[ALPHA_W-1:0];
          REG_PRESS_THRESHOLD: press_thr    = cfg_data[15:0];
          REG_RELEASE_THRESH:  release_thr  = cfg_data[16:0];
          REG_DEBOUNCE:        debounce_len = cfg_data[7:0];
          REG_PRESS_RISING:    rising       = cfg_data[0];
          default: ;
        endcase
      end
      // result side first, so a new request never matches in its own cycle
      if (out_valid && !out_stall) begin
        if (touch_results_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %b", $time, out_data);
          errors++;
        end else begin
          exp_res = touch_results_q.pop_front();
          check_bit("press_event", exp_res.press_event, out_data.press_event);
          check_bit("held", exp_res.held, out_data.held);
          check_bit("sample_taken", exp_res.sample_taken, out_data.sample_taken);
        end
      end
      if (in_valid && !in_stall) touch_results_q.push_back(predict_touch(in_data));
    end
    fail_count <= errors;
    pending    <= touch_results_q.size();
  end

endmodule

/* tb/sv/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the touch pad baseline / debounce detector.
// A short directed run covers the interval gate (boundary and wraparound),
// seeding, unity and above-unity gains, zero debounce and extreme
// thresholds; random phases then replay press / release gestures with noise
// under changing register settings, with random gaps on both channels.
// ---------------------------------------------------------------------------
module tb;
  import tbdd_pkg::*;

  localparam int IDLE_LIMIT    = 2000;  // covers the slowest request plus the longest random gaps
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 50;
  localparam int RANDOM_PHASES = 12;
  localparam int LONG_PHASE    = 7;     // phase with the longest debounce
  localparam int PHASE_ITEMS   = 60;
  localparam int RAW_MAX       = 65535;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int         fail_count;
  int         pending;
  logic       calm        = 1'b0;
  int         idle_cycles = 0;
  logic [3:0] rx_wait     = '0;

  // settings of the current phase
  logic [15:0]        set_interval;
  logic [ALPHA_W-1:0] set_filt;
  logic [ALPHA_W-1:0] set_base;
  logic [15:0]        set_press;
  logic signed [16:0] set_release;
  logic [7:0]         set_debounce;
  logic               set_rising;

  logic [31:0] now_ms;
  int          base_raw;
  int          sent_items;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  touch_baseline_debounce_detect dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tbdd_monitor u_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // receiver: stall a random number of cycles on each result request
  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait   <= '0;
    end else if (out_valid && !out_stall) begin
      w = calm ? 0 : $urandom_range(0, 14);
      rx_wait   <= 4'(w);
      out_stall <= (w != 0);
    end else if (out_valid && rx_wait != 0) begin
      rx_wait   <= rx_wait - 4'd1;
      out_stall <= (rx_wait > 4'd1);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [15:0] clamp_raw(input int v);
    if (v < 0) return '0;
    if (v > RAW_MAX) return '1;
    return 16'(v);
  endfunction

  task automatic send_request(input logic [31:0] t, input logic [15:0] raw);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{time_ms: t, raw_sample: raw};
    do @(posedge clk); while (in_stall);
  endtask

  // wait until every result is back, then a few more cycles
  task automatic drain_results(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_regs();
    set_reg(REG_SAMPLE_INTERVAL, CFG_W'(set_interval));
    set_reg(REG_FILTER_ALPHA, CFG_W'(set_filt));
    set_reg(REG_BASELINE_ALPHA, CFG_W'(set_base));
    set_reg(REG_PRESS_THRESHOLD, CFG_W'(set_press));
    set_reg(REG_RELEASE_THRESH, CFG_W'(set_release));
    set_reg(REG_DEBOUNCE, CFG_W'(set_debounce));
    set_reg(REG_PRESS_RISING, CFG_W'(set_rising));
    cfg_we <= 1'b0;
  endtask

  task automatic draw_settings(input int phase);
    case ($urandom_range(0, 9))
      0:       set_interval = '0;
      1:       set_interval = '1;
      default: set_interval = 16'($urandom_range(1, 40));
    endcase
    case ($urandom_range(0, 9))
      0:       set_filt = 17'd65536;
      1:       set_filt = '1;
      2:       set_filt = '0;
      default: set_filt = 17'($urandom_range(16384, 65536));
    endcase
    case ($urandom_range(0, 9))
      0:       set_base = '0;
      1:       set_base = 17'd65536;
      2:       set_base = '1;
      3:       set_base = RST_BASELINE_ALPHA;
      default: set_base = 17'($urandom_range(0, 8000));
    endcase
    case ($urandom_range(0, 9))
      0:       set_press = '0;
      1:       set_press = '1;
      default: set_press = 16'($urandom_range(20, 3000));
    endcase
    case ($urandom_range(0, 9))
      0:       set_release = -17'sd65535;
      1:       set_release = 17'sd65535;
      2:       set_release = 17'(int'($urandom_range(0, 131070)) - 65535);
      default: set_release = 17'(int'(set_press) - int'($urandom_range(1, set_press / 2 + 2)));
    endcase
    if (phase == LONG_PHASE) begin
      set_debounce = CNT_MAX;
    end else begin
      case ($urandom_range(0, 9))
        0:       set_debounce = '0;
        1:       set_debounce = 8'd12;
        default: set_debounce = 8'($urandom_range(1, 6));
      endcase
    end
    set_rising = 1'($urandom_range(0, 1));
  endtask

  // one reading: mostly on schedule, some too early, some at a random time
  task automatic emit_sample(input int level);
    logic [31:0] t;
    logic [15:0] raw;
    if ($urandom_range(0, 19) == 0) raw = 16'($urandom);
    else raw = clamp_raw(level + int'($urandom_range(0, 16)) - 8);
    case ($urandom_range(0, 9))
      0: t = now_ms + ((set_interval == 0) ? 32'd0 : 32'($urandom_range(0, set_interval - 1)));
      1: t = $urandom;
      default: t = now_ms + 32'(set_interval) + 32'($urandom_range(0, 3));
    endcase
    now_ms = t;
    send_request(t, raw);
    sent_items++;
  endtask

  // quiet readings, a touch of random depth and length, then quiet again
  task automatic run_gesture();
    int depth;
    int touch;
    int hold;
    int lead;
    int tail;
    depth = $urandom_range(int'(set_press) / 2, int'(set_press) * 2 + 10);
    if (depth > RAW_MAX) depth = RAW_MAX;
    touch = set_rising ? base_raw + depth : base_raw - depth;
    hold  = $urandom_range(int'(set_debounce) / 2, int'(set_debounce) + 4) + 1;
    tail  = $urandom_range(int'(set_debounce) / 2, int'(set_debounce) + 4) + 1;
    lead  = $urandom_range(0, 3);
    repeat (lead) emit_sample(base_raw);
    repeat (hold) emit_sample(touch);
    repeat (tail) emit_sample(base_raw);
    base_raw = int'(clamp_raw(base_raw + int'($urandom_range(0, 40)) - 20));
  endtask

  initial begin
    int budget;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: seeding, early reading, boundary across the wrap, press
    now_ms = 32'hFFFF_FFF0;
    send_request(now_ms, 16'hFFFF);
    send_request(now_ms + 32'd19, 16'h0000);
    now_ms = now_ms + 32'd20;
    send_request(now_ms, 16'hFFFF);
    repeat (5) begin
      now_ms = now_ms + 32'd20;
      send_request(now_ms, 16'h0000);
    end
    now_ms = now_ms + 32'd21;
    send_request(now_ms, 16'hFFFF);
    drain_results(SETTLE_CYCLES);

    // no gate, unity filter, baseline gain above one, zero debounce
    calm         = 1'b1;
    set_interval = '0;
    set_filt     = 17'd65536;
    set_base     = '1;
    set_press    = '0;
    set_release  = -17'sd65535;
    set_debounce = '0;
    set_rising   = 1'b1;
    set_reg(REG_UNUSED, '1);
    program_regs();
    send_request(now_ms, 16'h0000);
    send_request(now_ms, 16'hFFFF);
    send_request(now_ms, 16'h0000);
    send_request(now_ms, 16'h8000);
    send_request(now_ms, 16'h7FFF);
    send_request(now_ms, 16'h0000);
    drain_results(SETTLE_CYCLES);

    // longest gate, full-scale thresholds, debounce of one, falling polarity
    calm         = 1'b0;
    set_interval = '1;
    set_base     = '0;
    set_press    = '1;
    set_release  = 17'sd65535;
    set_debounce = 8'd1;
    set_rising   = 1'b0;
    program_regs();
    now_ms = now_ms + 32'd65535;
    send_request(now_ms, 16'hFFFF);
    send_request(now_ms + 32'd65534, 16'h0000);
    now_ms = now_ms + 32'd65535;
    send_request(now_ms, 16'h0000);
    now_ms = now_ms + 32'd65535;
    send_request(now_ms, 16'h0000);
    now_ms = now_ms + 32'd65535;
    send_request(now_ms, 16'hFFFF);
    drain_results(SETTLE_CYCLES);

    // random phases of gestures; the long-debounce phase runs one gesture
    base_raw = $urandom_range(20000, 45000);
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      draw_settings(phase);
      program_regs();
      calm       = (phase % 4 == 2);
      budget     = (phase == LONG_PHASE) ? int'(CNT_MAX) : PHASE_ITEMS;
      sent_items = 0;
      while (sent_items < budget) run_gesture();
      drain_results(SETTLE_CYCLES);
    end

    drain_results(DRAIN_CYCLES);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
